### hw/rtl/pixel_channel_normalizer_macros.svh
// Assertion macros used by the normalizer port checker.
`ifndef PIXEL_CHANNEL_NORMALIZER_MACROS_SVH
`define PIXEL_CHANNEL_NORMALIZER_MACROS_SVH

// Property that must hold at every edge, reset included.
`define PCN_ASSERT_HOLDS(name, clk, expr, msg) \
    name: assert property (@(posedge clk) (expr)) else $error(msg);

// Same-cycle implication, off during reset.
`define PCN_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PCN_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pcn_pkg.sv
// Shared types and constants of the pixel channel normalizer.
package pcn_pkg;

    localparam int MAX_FRAME_PIXELS = 1048576;

    localparam int CNT_W   = 20;
    localparam int FS_W    = 21;
    localparam int IDX_W   = 22;
    localparam int NORM_W  = 40;
    localparam int MEAN_W  = 16;
    localparam int RECIP_W = 24;
    localparam int NCH     = 3;

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Queue depths are powers of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    // Pixel format codes.
    localparam logic [2:0] FMT_RGB  = 3'd0;
    localparam logic [2:0] FMT_BGR  = 3'd1;
    localparam logic [2:0] FMT_RGBA = 3'd2;
    localparam logic [2:0] FMT_BGRA = 3'd3;
    localparam logic [2:0] FMT_ARGB = 3'd4;
    localparam logic [2:0] FMT_ABGR = 3'd5;
    localparam logic [2:0] FMT_GRAY = 3'd6;

    // Register indexes.
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [2:0] REG_PLANAR_LAYOUT = 3'd1;
    localparam logic [2:0] REG_OUTPUT_MODE   = 3'd2;
    localparam logic [2:0] REG_FRAME_SIZE    = 3'd3;
    localparam logic [2:0] REG_RED_NORM      = 3'd4;
    localparam logic [2:0] REG_GREEN_NORM    = 3'd5;
    localparam logic [2:0] REG_BLUE_NORM     = 3'd6;

    localparam logic OUT_BYTE = 1'b0;
    localparam logic OUT_Q16  = 1'b1;

    typedef struct packed {
        logic [2:0]                   pixel_format;
        logic                         planar_layout;
        logic                         output_mode;
        logic [FS_W-1:0]              frame_eff;
        logic [NCH-1:0][NORM_W-1:0]   norm;
    } cfg_t;

    typedef struct packed {
        logic [NCH-1:0][7:0] chan_byte;
        logic [1:0]          last_ch;
        logic [IDX_W-1:0]    base_idx;
    } pix_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [IDX_W-1:0] tensor_index;
        logic [31:0]      norm_value;
        logic             pixel_done;
    } result_t;

endpackage

### hw/rtl/pcn_regs.sv
// Configuration registers behind the APB-style port.
module pcn_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcn_pkg::PADDR_W-1:0]   paddr,
    input  logic [pcn_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcn_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output pcn_pkg::cfg_t                 cfg
);

    logic [2:0]                                          fmt_reg, fmt_next;
    logic                                                planar_reg, planar_next;
    logic                                                mode_reg, mode_next;
    logic [pcn_pkg::FS_W-1:0]                            fsize_reg, fsize_next;
    logic [pcn_pkg::NCH-1:0][pcn_pkg::NORM_W-1:0]        norm_reg, norm_next;
    logic                                                wr_en;
    logic [2:0]                                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[pcn_pkg::PADDR_W-1:3];

    always_comb
    begin
        fmt_next    = fmt_reg;
        planar_next = planar_reg;
        mode_next   = mode_reg;
        fsize_next  = fsize_reg;
        norm_next   = norm_reg;
        if (wr_en)
        begin
            case (reg_sel)
                pcn_pkg::REG_PIXEL_FORMAT:  fmt_next    = pwdata[2:0];
                pcn_pkg::REG_PLANAR_LAYOUT: planar_next = pwdata[0];
                pcn_pkg::REG_OUTPUT_MODE:   mode_next   = pwdata[0];
                pcn_pkg::REG_FRAME_SIZE:    fsize_next  = pwdata[pcn_pkg::FS_W-1:0];
                pcn_pkg::REG_RED_NORM:      norm_next[0] = pwdata[pcn_pkg::NORM_W-1:0];
                pcn_pkg::REG_GREEN_NORM:    norm_next[1] = pwdata[pcn_pkg::NORM_W-1:0];
                pcn_pkg::REG_BLUE_NORM:     norm_next[2] = pwdata[pcn_pkg::NORM_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= pcn_pkg::FMT_RGB;
            planar_reg <= 1'b0;
            mode_reg   <= pcn_pkg::OUT_BYTE;
            fsize_reg  <= pcn_pkg::FS_W'(1);
            for (int i = 0; i < pcn_pkg::NCH; i++)
            begin
                norm_reg[i] <= pcn_pkg::NORM_W'(65536);
            end
        end
        else
        begin
            fmt_reg    <= fmt_next;
            planar_reg <= planar_next;
            mode_reg   <= mode_next;
            fsize_reg  <= fsize_next;
            norm_reg   <= norm_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            pcn_pkg::REG_PIXEL_FORMAT:  prdata = pcn_pkg::PDATA_W'(fmt_reg);
            pcn_pkg::REG_PLANAR_LAYOUT: prdata = pcn_pkg::PDATA_W'(planar_reg);
            pcn_pkg::REG_OUTPUT_MODE:   prdata = pcn_pkg::PDATA_W'(mode_reg);
            pcn_pkg::REG_FRAME_SIZE:    prdata = pcn_pkg::PDATA_W'(fsize_reg);
            pcn_pkg::REG_RED_NORM:      prdata = pcn_pkg::PDATA_W'(norm_reg[0]);
            pcn_pkg::REG_GREEN_NORM:    prdata = pcn_pkg::PDATA_W'(norm_reg[1]);
            pcn_pkg::REG_BLUE_NORM:     prdata = pcn_pkg::PDATA_W'(norm_reg[2]);
            default:                    prdata = '0;
        endcase
    end

    // Clamp frame size to 1..MAX_FRAME_PIXELS.
    always_comb
    begin
        cfg.pixel_format  = fmt_reg;
        cfg.planar_layout = planar_reg;
        cfg.output_mode   = mode_reg;
        cfg.norm          = norm_reg;
        if (fsize_reg == '0)
            cfg.frame_eff = pcn_pkg::FS_W'(1);
        else if (fsize_reg > pcn_pkg::FS_W'(pcn_pkg::MAX_FRAME_PIXELS))
            cfg.frame_eff = pcn_pkg::FS_W'(pcn_pkg::MAX_FRAME_PIXELS);
        else
            cfg.frame_eff = fsize_reg;
    end

endmodule

### hw/rtl/pcn_front.sv
// Front end: accepts pixels, picks channel bytes and tracks the pixel counter.
module pcn_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcn_pkg::cfg_t        cfg,
    input  logic                 push,
    input  logic [31:0]          pixel_word,
    input  logic                 frame_start,
    input  pcn_pkg::q_status_t   q_stat,
    output logic                 q_wr,
    output pcn_pkg::pix_rec_t    rec
);

    logic [pcn_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [pcn_pkg::CNT_W-1:0] cur_cnt;
    logic [pcn_pkg::CNT_W:0]   cnt_inc;
    logic [pcn_pkg::NCH-1:0][1:0] pos;
    logic                      gray;

    assign q_wr    = push && !q_stat.full;
    assign cur_cnt = frame_start ? '0 : cnt_reg;
    assign cnt_inc = {1'b0, cur_cnt} + (pcn_pkg::CNT_W+1)'(1);
    assign gray    = (cfg.pixel_format == pcn_pkg::FMT_GRAY);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (q_wr)
        begin
            if (cnt_inc >= cfg.frame_eff)
                cnt_next = '0;
            else
                cnt_next = cnt_inc[pcn_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Byte positions in R,G,B order; unknown codes read as RGB.
    always_comb
    begin
        case (cfg.pixel_format) inside
            pcn_pkg::FMT_BGR, pcn_pkg::FMT_BGRA: pos = {2'd0, 2'd1, 2'd2};
            pcn_pkg::FMT_ARGB:                   pos = {2'd3, 2'd2, 2'd1};
            pcn_pkg::FMT_ABGR:                   pos = {2'd1, 2'd2, 2'd3};
            pcn_pkg::FMT_GRAY:                   pos = {2'd0, 2'd0, 2'd0};
            default:                             pos = {2'd2, 2'd1, 2'd0};
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < pcn_pkg::NCH; c++)
        begin
            rec.chan_byte[c] = pixel_word[{pos[c], 3'b000} +: 8];
        end
        rec.last_ch = gray ? 2'd0 : 2'(pcn_pkg::NCH - 1);
        if (cfg.planar_layout || gray)
            rec.base_idx = pcn_pkg::IDX_W'(cur_cnt);
        else
            rec.base_idx = pcn_pkg::IDX_W'({cur_cnt, 1'b0}) + pcn_pkg::IDX_W'(cur_cnt);
    end

endmodule

### hw/rtl/pcn_queue.sv
// Short pixel queue between the front and back ends.
module pcn_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  pcn_pkg::pix_rec_t    wr_rec,
    input  logic                 rd,
    output pcn_pkg::pix_rec_t    head,
    output pcn_pkg::q_status_t   q_stat
);

    pcn_pkg::pix_rec_t            mem_reg [pcn_pkg::QUEUE_DEPTH];
    logic [pcn_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pcn_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == pcn_pkg::QCNT_W'(pcn_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
            cnt_next = cnt_reg + pcn_pkg::QCNT_W'(1);
        else if (rd && !wr)
            cnt_next = cnt_reg - pcn_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + pcn_pkg::QPTR_W'(1);
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + pcn_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

### hw/rtl/pcn_back.sv
// Back end: steps channels, multiplies, saturates and buffers results.
module pcn_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcn_pkg::cfg_t               cfg,
    input  pcn_pkg::pix_rec_t           head,
    input  pcn_pkg::q_status_t          q_stat,
    output logic                        q_rd,
    input  logic                        pop,
    output logic                        empty,
    output logic [pcn_pkg::IDX_W-1:0]   tensor_index,
    output logic signed [31:0]          norm_value,
    output logic                        pixel_done
);

    // Channel sequencer
    logic [1:0]                   ch_reg, ch_next;
    logic [pcn_pkg::IDX_W-1:0]    acc_reg, acc_next;
    logic [pcn_pkg::IDX_W-1:0]    cur_idx, stride;
    logic                         issue, last;
    logic [pcn_pkg::NORM_W-1:0]   norm_sel;
    logic [7:0]                   byte_sel;

    // Stage 1: difference and reciprocal
    logic                         v1_reg;
    logic signed [16:0]           diff1_reg;
    logic [pcn_pkg::RECIP_W-1:0]  recip1_reg;
    logic [pcn_pkg::IDX_W-1:0]    idx1_reg;
    logic                         done1_reg;

    // Stage 2: product
    logic                         v2_reg;
    logic signed [40:0]           prod2_reg;
    logic [pcn_pkg::IDX_W-1:0]    idx2_reg;
    logic                         done2_reg;
    logic signed [40:0]           prod_full;

    // Saturation
    logic signed [41:0]           rnd;
    logic signed [33:0]           q_sh;
    logic [31:0]                  sat_val;

    // Result buffer
    pcn_pkg::result_t             res_reg [pcn_pkg::OUT_DEPTH];
    pcn_pkg::result_t             res_in;
    logic [pcn_pkg::OPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pcn_pkg::OCNT_W-1:0]   cnt_reg, cnt_next;
    logic [pcn_pkg::OCNT_W:0]     in_flight;
    logic                         out_rd;

    // Issue only while the result buffer has room for everything in flight.
    assign in_flight = (pcn_pkg::OCNT_W+1)'(cnt_reg) + (pcn_pkg::OCNT_W+1)'(v1_reg)
                     + (pcn_pkg::OCNT_W+1)'(v2_reg);
    assign issue     = !q_stat.empty && (in_flight < (pcn_pkg::OCNT_W+1)'(pcn_pkg::OUT_DEPTH));
    assign last      = (ch_reg == head.last_ch);
    assign q_rd      = issue && last;
    assign cur_idx   = (ch_reg == 2'd0) ? head.base_idx : acc_reg;
    assign stride    = cfg.planar_layout ? pcn_pkg::IDX_W'(cfg.frame_eff)
                                         : pcn_pkg::IDX_W'(1);
    assign norm_sel  = cfg.norm[ch_reg];
    assign byte_sel  = head.chan_byte[ch_reg];

    always_comb
    begin
        ch_next  = ch_reg;
        acc_next = acc_reg;
        if (issue)
        begin
            if (last)
                ch_next = 2'd0;
            else
                ch_next = ch_reg + 2'd1;
            acc_next = cur_idx + stride;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= 2'd0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            ch_reg <= ch_next;
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    assign prod_full = diff1_reg * $signed({1'b0, recip1_reg});

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        diff1_reg  <= $signed({1'b0, byte_sel, 8'h00})
                    - $signed({1'b0, norm_sel[pcn_pkg::NORM_W-1:pcn_pkg::RECIP_W]});
        recip1_reg <= norm_sel[pcn_pkg::RECIP_W-1:0];
        idx1_reg   <= cur_idx;
        done1_reg  <= last;
        prod2_reg  <= prod_full;
        idx2_reg   <= idx1_reg;
        done2_reg  <= done1_reg;
    end

    // Round half away from zero: +128 for positive, +127 for negative, then shift.
    assign rnd  = 42'(prod2_reg) + (prod2_reg[40] ? 42'sd127 : 42'sd128);
    assign q_sh = rnd[41:8];

    always_comb
    begin
        if (cfg.output_mode == pcn_pkg::OUT_Q16)
        begin
            if (q_sh[33:31] == 3'b000 || q_sh[33:31] == 3'b111)
                sat_val = q_sh[31:0];
            else if (q_sh[33])
                sat_val = 32'h8000_0000;
            else
                sat_val = 32'h7FFF_FFFF;
        end
        else
        begin
            if (prod2_reg[40] || prod2_reg == '0)
                sat_val = 32'd0;
            else if (prod2_reg[39:32] != 8'd0)
                sat_val = 32'd255;
            else
                sat_val = {24'd0, prod2_reg[31:24]};
        end
    end

    assign res_in.tensor_index = idx2_reg;
    assign res_in.norm_value   = sat_val;
    assign res_in.pixel_done   = done2_reg;

    assign out_rd = pop && (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (v2_reg && !out_rd)
            cnt_next = cnt_reg + pcn_pkg::OCNT_W'(1);
        else if (out_rd && !v2_reg)
            cnt_next = cnt_reg - pcn_pkg::OCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (v2_reg)
                wr_ptr_reg <= wr_ptr_reg + pcn_pkg::OPTR_W'(1);
            if (out_rd)
                rd_ptr_reg <= rd_ptr_reg + pcn_pkg::OPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
            res_reg[wr_ptr_reg] <= res_in;
    end

    assign empty        = (cnt_reg == '0);
    assign tensor_index = res_reg[rd_ptr_reg].tensor_index;
    assign norm_value   = $signed(res_reg[rd_ptr_reg].norm_value);
    assign pixel_done   = res_reg[rd_ptr_reg].pixel_done;

endmodule

### hw/rtl/pixel_channel_normalizer.sv
// Top level of the per-channel mean / standard-deviation normalizer.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+----------------------------------------
//  pixel in  | push / full                   | pixel_word, frame_start
//  result    | empty / pop                   | tensor_index, norm_value, pixel_done
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata (64-bit, 8*i map)
//
// A color pixel gives 3 channel results, a gray pixel 1. While a pixel waits and the
// result buffer has room, the back-end channel sequencer issues one multiply per cycle.
// A result is visible once it has passed the pixel queue, stage 1, stage 2 and the buffer.
// Reset clears the counter, queues and registers; no clearing pass is needed.
// A stalled result side fills the 4-entry result buffer, then the 2-entry pixel
// queue, and only then raises full.
module pixel_channel_normalizer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcn_pkg::PADDR_W-1:0]   paddr,
    input  logic [pcn_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcn_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [31:0]                   pixel_word,
    input  logic                          frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic [pcn_pkg::IDX_W-1:0]     tensor_index,
    output logic signed [31:0]            norm_value,
    output logic                          pixel_done
);

    pcn_pkg::cfg_t       cfg;
    pcn_pkg::pix_rec_t   wr_rec;
    pcn_pkg::pix_rec_t   head;
    pcn_pkg::q_status_t  q_stat;
    logic                q_wr;
    logic                q_rd;

    assign full = q_stat.full;

    pcn_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcn_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .push        (push),
        .pixel_word  (pixel_word),
        .frame_start (frame_start),
        .q_stat      (q_stat),
        .q_wr        (q_wr),
        .rec         (wr_rec)
    );

    pcn_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_rec (wr_rec),
        .rd     (q_rd),
        .head   (head),
        .q_stat (q_stat)
    );

    pcn_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .q_stat       (q_stat),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .tensor_index (tensor_index),
        .norm_value   (norm_value),
        .pixel_done   (pixel_done)
    );

endmodule

### hw/rtl/pcn_port_checker.sv
// Port-level assertions for the normalizer, bound to the top level.
`include "pixel_channel_normalizer_macros.svh"

module pcn_port_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [pcn_pkg::IDX_W-1:0]     tensor_index,
    input  logic signed [31:0]            norm_value,
    input  logic                          pixel_done
);

    // Nothing waits on the result side while in reset.
    `PCN_ASSERT_HOLDS(a_reset_empty, clk, rst_n || empty, "result side not empty in reset")

    // A waiting result holds until it is taken.
    `PCN_ASSERT_NEXT(a_result_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(tensor_index) && $stable(norm_value) && $stable(pixel_done),
        "waiting result changed")

    // The input side fills only through an accepted request.
    `PCN_ASSERT_IMPLY(a_full_cause, clk, rst_n, $rose(full), $past(push && !full),
        "full rose without an accepted request")

    // The result side drains only through an accepted pop.
    `PCN_ASSERT_IMPLY(a_empty_cause, clk, rst_n, $rose(empty), $past(pop && !empty),
        "empty rose without an accepted pop")

endmodule

bind pixel_channel_normalizer pcn_port_checker u_port_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .tensor_index (tensor_index),
    .norm_value   (norm_value),
    .pixel_done   (pixel_done)
);
